// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int WORD_BITS    = 64;
    localparam int BIT_W        = 6;
    localparam int MAX_BLOCKS_D = 4096;

    localparam int ACTION_W = 2;
    localparam int BLOCK_W  = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 13;

    localparam logic [COUNT_W-1:0] BLOCKS_RST   = 13'd4096;
    localparam logic [COUNT_W-1:0] RESERVED_RST = 13'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_FORMAT = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE   = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_REJECT = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_BLOCKS   = 1'b0,
        REG_RESERVED = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } lz_t;

    // lowest clear bit of a map or summary word
    function automatic lz_t lowest_zero(input logic [WORD_BITS-1:0] w);
        lz_t r;
        r.found = ~&w;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r.idx = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used/free bitmap with a per-word full
// summary and a free block count.
// ----------------------------------------------------------------------------
// steps: allocate scans 64-word summary chunks in turn, then checks one map word;
//   free writes its map word; rejected free and unused action go to done;
//   format writes one map word per cycle through one port
// one item at a time; the next item is taken once the result is registered
// reset: after rst_n rises a clearing pass over every map word
//   wipes map and summary; no word is taken until it ends
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_D
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // action[1:0], block_number[13:2]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // granted_block[11:0], status[13:12],
                                        // free_blocks[26:14]
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int SUM_WORDS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int IDX_W     = $clog2(MAX_BLOCKS);
    localparam int CMP_W     = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SWEEP   = 6'b000010,
        ST_SUM_CHK = 6'b000100,
        ST_MAP_CHK = 6'b001000,
        ST_FREE_WR = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]   blocks_reg, reserved_reg;
    logic [COUNT_W-1:0]   free_total_reg, free_total_next;
    logic [MAP_AW-1:0]    word_reg, word_next;
    logic [SUM_AW-1:0]    chunk_reg, chunk_next;
    logic                 clear_run_reg, clear_run_next;
    logic [BLOCK_W-1:0]   bn_reg, bn_next;
    logic [BLOCK_W-1:0]   res_granted_reg, res_granted_next;
    status_t              res_status_reg, res_status_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic                 m_valid_reg;
    logic [BLOCK_W-1:0]   out_granted_reg;
    status_t              out_status_reg;
    logic [COUNT_W-1:0]   out_free_reg;
    logic                 out_load;

    logic                 map_we, sum_we;
    logic [WORD_BITS-1:0] map_wdata, sum_wdata, map_rdata, sum_rdata;
    logic [SUM_AW-1:0]    sum_waddr;

    action_t              in_action;
    logic [BLOCK_W-1:0]   in_block;
    logic [COUNT_W-1:0]   eff_total, marks, sweep_marks;
    logic [MAP_AW-1:0]    in_word;
    lz_t                  lz_sum, lz_map;
    logic [CMP_W-1:0]     sum_word_idx, alloc_blk, sweep_base;
    logic                 sweep_full, sweep_part, word_last, chunk_last, cfg_we;
    logic [BIT_W-1:0]     sweep_n;
    logic [WORD_BITS-1:0] sweep_pattern, acc_new, grant_word;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;
    assign prdata = (reg_index_t'(paddr[2]) == REG_RESERVED) ? 32'(reserved_reg)
                                                              : 32'(blocks_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg   <= BLOCKS_RST;
            reserved_reg <= RESERVED_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(paddr[2]))
                REG_BLOCKS:   blocks_reg   <= pwdata[COUNT_W-1:0];
                REG_RESERVED: reserved_reg <= pwdata[COUNT_W-1:0];
                default:      blocks_reg   <= blocks_reg;
            endcase
        end
    end

    // ---------------- storage ----------------
    bba_ram #(.DEPTH(MAP_WORDS), .AW(MAP_AW)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (word_reg),
        .wdata (map_wdata),
        .raddr (word_next),
        .rdata (map_rdata)
    );

    // one bit per map word, set when the word is full
    bba_ram #(.DEPTH(SUM_WORDS), .AW(SUM_AW)) u_sum (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (chunk_next),
        .rdata (sum_rdata)
    );

    // ---------------- shared datapath ----------------
    assign in_action = action_t'(s_tdata[ACTION_W-1:0]);
    assign in_block  = s_tdata[ACTION_W +: BLOCK_W];
    assign in_word   = MAP_AW'(in_block >> BIT_W);
    assign sum_waddr = SUM_AW'(word_reg >> BIT_W);

    assign eff_total = (CMP_W'(blocks_reg) > CMP_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS)
                                                                  : blocks_reg;
    assign marks     = (CMP_W'(reserved_reg) > CMP_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS)
                                                                    : reserved_reg;

    assign lz_sum       = lowest_zero(sum_rdata);
    assign lz_map       = lowest_zero(map_rdata);
    assign sum_word_idx = CMP_W'({chunk_reg, lz_sum.idx});
    assign alloc_blk    = CMP_W'({word_reg, lz_map.idx});
    assign grant_word   = map_rdata | (WORD_BITS'(1) << lz_map.idx);
    assign chunk_last   = (chunk_reg == SUM_AW'(SUM_WORDS - 1));
    assign word_last    = (word_reg == MAP_AW'(MAP_WORDS - 1));

    // format pattern of the current sweep word; the clearing pass marks nothing
    assign sweep_marks   = clear_run_reg ? '0 : marks;
    assign sweep_base    = CMP_W'({word_reg, BIT_W'(0)});
    assign sweep_full    = CMP_W'(sweep_marks) >= sweep_base + CMP_W'(WORD_BITS);
    assign sweep_part    = CMP_W'(sweep_marks) > sweep_base;
    assign sweep_n       = BIT_W'(CMP_W'(sweep_marks) - sweep_base);
    assign sweep_pattern = sweep_full ? '1
                         : (sweep_part ? ~({WORD_BITS{1'b1}} << sweep_n) : '0);
    assign acc_new = ((BIT_W'(word_reg) == '0) ? '0 : acc_reg)
                   | (WORD_BITS'(sweep_full) << BIT_W'(word_reg));

    assign s_tready = (state_reg == ST_IDLE);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        word_next        = word_reg;
        chunk_next       = chunk_reg;
        clear_run_next   = clear_run_reg;
        bn_next          = bn_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        free_total_next  = free_total_reg;
        acc_next         = acc_reg;
        map_we           = 1'b0;
        map_wdata        = map_rdata;
        sum_we           = 1'b0;
        sum_wdata        = sum_rdata;
        out_load         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bn_next          = in_block;
                    res_granted_next = '0;
                    res_status_next  = STAT_DONE;
                    unique case (in_action)
                        ACT_ALLOC:
                        begin
                            chunk_next = '0;
                            state_next = ST_SUM_CHK;
                        end
                        ACT_FREE:
                        begin
                            if (in_block == '0 || CMP_W'(in_block) >= CMP_W'(eff_total))
                            begin
                                res_status_next = STAT_REJECT;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                word_next  = in_word;
                                chunk_next = SUM_AW'(in_word >> BIT_W);
                                state_next = ST_FREE_WR;
                            end
                        end
                        ACT_FORMAT:
                        begin
                            word_next  = '0;
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SWEEP:
            begin
                map_we    = 1'b1;
                map_wdata = sweep_pattern;
                sum_we    = 1'b1;
                sum_wdata = acc_new;
                acc_next  = acc_new;
                if (word_last)
                begin
                    word_next = '0;
                    if (clear_run_reg)
                    begin
                        clear_run_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        free_total_next = (eff_total > reserved_reg)
                                        ? eff_total - reserved_reg : '0;
                        state_next      = ST_DONE;
                    end
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end

            ST_SUM_CHK:
            begin
                // a clear bit past the last map word counts as no free word
                if (lz_sum.found && sum_word_idx < CMP_W'(MAP_WORDS))
                begin
                    word_next  = MAP_AW'(sum_word_idx);
                    state_next = ST_MAP_CHK;
                end
                else if (chunk_last)
                begin
                    res_status_next = STAT_FULL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end

            ST_MAP_CHK:
            begin
                state_next = ST_DONE;
                if (!lz_map.found || alloc_blk >= CMP_W'(eff_total))
                begin
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    map_we           = 1'b1;
                    map_wdata        = grant_word;
                    sum_we           = &grant_word;
                    sum_wdata        = sum_rdata | (WORD_BITS'(1) << BIT_W'(word_reg));
                    res_granted_next = BLOCK_W'(alloc_blk);
                    if (free_total_reg != '0)
                    begin
                        free_total_next = free_total_reg - 1'b1;
                    end
                end
            end

            ST_FREE_WR:
            begin
                map_we          = 1'b1;
                map_wdata       = map_rdata & ~(WORD_BITS'(1) << bn_reg[BIT_W-1:0]);
                sum_we          = 1'b1;
                sum_wdata       = sum_rdata & ~(WORD_BITS'(1) << BIT_W'(word_reg));
                free_total_next = (free_total_reg < eff_total) ? free_total_reg + 1'b1
                                                               : eff_total;
                state_next      = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            clear_run_reg  <= 1'b1;
            word_reg       <= '0;
            chunk_reg      <= '0;
            free_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_run_reg  <= clear_run_next;
            word_reg       <= word_next;
            chunk_reg      <= chunk_next;
            free_total_reg <= free_total_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bn_reg          <= bn_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        acc_reg         <= acc_next;
        if (out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_status_reg  <= res_status_reg;
            out_free_reg    <= free_total_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_free_reg, out_status_reg, out_granted_reg};

`ifndef SYNTHESIS
    a_chunk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM_CHK) |-> (chunk_reg <= SUM_AW'(SUM_WORDS - 1)))
        else $error("summary scan ran past the last chunk");

    a_grant_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAP_CHK && map_we) |-> !map_rdata[lz_map.idx])
        else $error("allocate granted a block already in use");

    a_free_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREE_WR) |-> $past(state_reg == ST_IDLE))
        else $error("free write without a fresh map read");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the done step");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        clear_run_reg |-> !s_tready)
        else $error("request taken during the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== hdl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Single write port, single read port word store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram
    import bba_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_block_allocator. Requests go in over the
// slave stream and every accepted word is run through an in-bench model of
// the usage map and free count. Each result word is checked against the
// oldest predicted outcome. Volume and reserved sizes are reprogrammed over
// apb between phases.
// ----------------------------------------------------------------------------

module tb;
    import bba_pkg::*;

    localparam int MAP_WORDS = MAX_BLOCKS_D / WORD_BITS;

    typedef struct packed {
        logic [BLOCK_W-1:0] granted;
        status_t            status;
        logic [COUNT_W-1:0] free_cnt;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // action[1:0], block_number[13:2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // granted_block[11:0], status[13:12],
                                   // free_blocks[26:14]

    // model of the allocator state
    logic [WORD_BITS-1:0] used_map [MAP_WORDS];
    logic [COUNT_W-1:0]   model_free = '0;
    logic [COUNT_W-1:0]   vol_blocks = BLOCKS_RST;
    logic [COUNT_W-1:0]   reserved_blocks = RESERVED_RST;

    outcome_t pending_outcomes[$];

    int errors = 0;
    int words_sent = 0;
    int grants = 0;
    int full_answers = 0;
    int rejects = 0;
    int formats = 0;
    int burst_left = 0;
    bit steady_sender = 1'b0;
    int rx_cycles = 0;
    int rx_mode = 0;
    int hold_end = 0;

    bitmap_block_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int volume_total();
        return (vol_blocks > MAX_BLOCKS_D) ? MAX_BLOCKS_D : int'(vol_blocks);
    endfunction

    // applies one request to the model and returns the result it gives
    function automatic outcome_t resolve_request(action_t act, logic [BLOCK_W-1:0] bn);
        outcome_t r;
        int total;
        int blk;
        int b;
        int marks;
        bit found;
        total = volume_total();
        r.granted = '0;
        r.status = STAT_DONE;
        case (act)
            ACT_ALLOC:
            begin
                found = 1'b0;
                blk = 0;
                for (int w = 0; w < MAP_WORDS && !found; w++)
                begin
                    if (used_map[w] != '1)
                    begin
                        b = 0;
                        while (used_map[w][b])
                            b++;
                        blk = w * WORD_BITS + b;
                        found = 1'b1;
                    end
                end
                if (!found || blk >= total)
                begin
                    r.status = STAT_FULL;
                    full_answers++;
                end
                else
                begin
                    used_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b1;
                    if (model_free > 0)
                        model_free--;
                    r.granted = BLOCK_W'(blk);
                    grants++;
                end
            end
            ACT_FREE:
            begin
                if (bn == 0 || int'(bn) >= total)
                begin
                    r.status = STAT_REJECT;
                    rejects++;
                end
                else
                begin
                    used_map[bn / WORD_BITS][bn % WORD_BITS] = 1'b0;
                    // freeing a clear bit still bumps the count
                    if (int'(model_free) < total)
                        model_free++;
                    else
                        model_free = COUNT_W'(total);
                end
            end
            ACT_FORMAT:
            begin
                marks = (reserved_blocks > MAX_BLOCKS_D) ? MAX_BLOCKS_D
                                                         : int'(reserved_blocks);
                for (int w = 0; w < MAP_WORDS; w++)
                    used_map[w] = '0;
                for (int i = 0; i < marks; i++)
                    used_map[i / WORD_BITS][i % WORD_BITS] = 1'b1;
                model_free = (total > reserved_blocks) ? COUNT_W'(total - reserved_blocks)
                                                       : '0;
                formats++;
            end
            default:
            begin
            end
        endcase
        r.free_cnt = model_free;
        return r;
    endfunction

    // one request word, sent in bursts with random gaps between them
    task automatic send_request(action_t act, logic [BLOCK_W-1:0] bn);
        int gap;
        if (burst_left == 0)
        begin
            gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, bn, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_outcomes.push_back(resolve_request(act, bn));
        words_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BLOCKS)
            vol_blocks = value;
        else
            reserved_blocks = value;
        @(posedge clk);
    endtask

    task automatic configure(int blocks, int reserved);
        write_reg(REG_BLOCKS, COUNT_W'(blocks));
        write_reg(REG_RESERVED, COUNT_W'(reserved));
    endtask

    // random request mix biased towards well-formed alloc/free traffic
    task automatic send_mixed(int count, int alloc_pct);
        int pick;
        int total;
        logic [BLOCK_W-1:0] bn;
        for (int n = 0; n < count; n++)
        begin
            total = volume_total();
            pick = $urandom_range(0, 99);
            bn = BLOCK_W'($urandom);
            if (pick < alloc_pct)
            begin
                send_request(ACT_ALLOC, bn);
            end
            else if (pick < 92)
            begin
                case ($urandom_range(0, 9))
                    0:       bn = '0;
                    1:       bn = BLOCK_W'(total > 4095 ? 4095 : total);
                    2:       bn = BLOCK_W'($urandom);
                    default: bn = (total > 1) ? BLOCK_W'($urandom_range(1, total - 1)) : '0;
                endcase
                send_request(ACT_FREE, bn);
            end
            else if (pick < 95)
            begin
                send_request(ACT_FORMAT, bn);
            end
            else
            begin
                send_request(ACT_NONE, bn);
            end
        end
    endtask

    task automatic test_unformatted_map();
        // map is clear after reset, so block 0 can be handed out
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '1);
        send_request(ACT_FREE, '0);
        send_request(ACT_FREE, 12'd4095);
        send_request(ACT_FREE, 12'd4095);
        send_request(ACT_NONE, 12'hFFF);
        send_request(ACT_ALLOC, 12'hABC);
        settle();
    endtask

    task automatic test_format_edges();
        // whole map reserved: no clear bit anywhere
        configure(4096, 4096);
        send_request(ACT_FORMAT, '0);
        send_request(ACT_ALLOC, '0);
        settle();
        // only the top block left
        configure(4096, 4095);
        send_request(ACT_FORMAT, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 12'd4095);
        settle();
        // single-block volume
        configure(1, 1);
        send_request(ACT_FORMAT, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, '0);
        send_request(ACT_FREE, 12'd1);
        settle();
        // reserved area larger than the volume
        configure(10, 20);
        send_request(ACT_FORMAT, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 12'd5);
        send_request(ACT_FREE, 12'd9);
        send_request(ACT_FREE, 12'd10);
        settle();
        // both registers above the map size
        configure(8191, 5000);
        send_request(ACT_FORMAT, '0);
        send_request(ACT_ALLOC, '0);
        settle();
    endtask

    task automatic test_mixed_volumes();
        int blocks;
        int reserved;
        int lo;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       blocks = $urandom_range(1, 64);
                1, 2:    blocks = $urandom_range(65, 300);
                3:
                begin
                    case ($urandom_range(0, 4))
                        0:       blocks = 1;
                        1:       blocks = 63;
                        2:       blocks = 64;
                        3:       blocks = 65;
                        default: blocks = 128;
                    endcase
                end
                4:       blocks = 4096;
                default: blocks = $urandom_range(301, 4096);
            endcase
            if (blocks > 300 && $urandom_range(0, 1) == 1)
            begin
                // leave only a short tail so the volume fills up
                lo = blocks - 150;
                reserved = $urandom_range(lo, blocks);
            end
            else if ($urandom_range(0, 4) == 0)
                reserved = $urandom_range(1, (blocks + 16 > 4096) ? 4096 : blocks + 16);
            else
                reserved = $urandom_range(1, 8);
            configure(blocks, reserved);
            send_request(ACT_FORMAT, BLOCK_W'($urandom));
            send_mixed(100, 55);
            settle();
        end
    endtask

    task automatic test_result_backpressure();
        configure(200, 3);
        send_request(ACT_FORMAT, '0);
        settle();
        // receiver holds off for a long stretch while requests keep coming
        hold_end = rx_cycles + 400;
        steady_sender = 1'b1;
        send_mixed(40, 60);
        steady_sender = 1'b0;
        settle();
    endtask

    task automatic test_full_volume();
        configure(4096, 2);
        send_request(ACT_FORMAT, '0);
        send_mixed(150, 50);
        settle();
    endtask

    // result side: check each accepted word, then pick the next ready
    always @(posedge clk)
    begin : result_side
        outcome_t got;
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.granted  = m_tdata[11:0];
            got.status   = status_t'(m_tdata[13:12]);
            got.free_cnt = m_tdata[26:14];
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.granted != want.granted)
                begin
                    $display("%0t: granted_block expected %0d actual %0d",
                             $time, want.granted, got.granted);
                    errors++;
                end
                if (got.status != want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.free_cnt != want.free_cnt)
                begin
                    $display("%0t: free_blocks expected %0d actual %0d",
                             $time, want.free_cnt, got.free_cnt);
                    errors++;
                end
            end
        end
        rx_cycles++;
        if (rx_cycles % 48 == 0)
            rx_mode = $urandom_range(0, 3);
        if (rx_cycles < hold_end)
            m_tready <= 1'b0;
        else
        begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= (rx_cycles % 4 == 3);
            endcase
        end
    end

    initial
    begin
        for (int w = 0; w < MAP_WORDS; w++)
            used_map[w] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unformatted_map();
        test_format_edges();
        test_mixed_volumes();
        test_result_backpressure();
        test_full_volume();
        settle();
        repeat (80) @(posedge clk);
        $display("sent %0d requests: %0d blocks granted, %0d full answers, %0d frees rejected",
                 words_sent, grants, full_answers, rejects);
        $display("%0d formats across volume sizes from 1 to the whole map, one long result stall",
                 formats);
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
